// ----- design/ssgm_pkg.sv -----
// Shared constants, types and helpers for the slewed sensor gauge mapper.
`default_nettype none

package ssgm_pkg;

  // Sensor modes held in the mode register
  localparam logic [2:0] MODE_CO2      = 3'd0;
  localparam logic [2:0] MODE_PM10     = 3'd1;
  localparam logic [2:0] MODE_PM2_5    = 3'd2;
  localparam logic [2:0] MODE_TEMP     = 3'd3;
  localparam logic [2:0] MODE_HUMIDITY = 3'd4;
  localparam logic [2:0] MODE_PRESSURE = 3'd5;

  // Register map: word index taken from the address
  localparam logic REG_SENSOR_MODE = 1'b0;

  // Input item operations
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Floors applied before the step
  localparam logic [15:0] CO2_FLOOR      = 16'd352;
  localparam logic [15:0] PRESSURE_FLOOR = 16'd976;

  // Bar lengths for the full-ring cases
  localparam logic [5:0] BAR_HALF = 6'd16;
  localparam logic [5:0] BAR_FULL = 6'd32;

  typedef enum logic [3:0] {
    COL_BLUE        = 4'd0,
    COL_GREEN       = 4'd1,
    COL_YELLOW      = 4'd2,
    COL_RED         = 4'd3,
    COL_MAGENTA     = 4'd4,
    COL_DARKBLUE    = 4'd5,
    COL_ORANGE      = 4'd6,
    COL_CYAN        = 4'd7,
    COL_GREENYELLOW = 4'd8
  } color_t;

  // x / 6 for x up to 96, by reciprocal 43/256
  function automatic logic [4:0] div6(input logic [6:0] x);
    logic [12:0] p;
    p = {6'd0, x} * 13'd43;
    return p[12:8];
  endfunction

  // x / 5 for x up to 80, by reciprocal 205/1024
  function automatic logic [4:0] div5(input logic [6:0] x);
    logic [14:0] p;
    p = {8'd0, x} * 15'd205;
    return p[14:10];
  endfunction

  // x / 3 for x up to 48, by reciprocal 171/512
  function automatic logic [4:0] div3(input logic [5:0] x);
    logic [13:0] p;
    p = {8'd0, x} * 14'd171;
    return p[13:9];
  endfunction

endpackage

`default_nettype wire

// ----- design/slewed_sensor_gauge_mapper.sv -----
// Top level of the slewed sensor gauge mapper: item path, state and register port.
//
// Usage
//   Input channel (in_valid/in_ready): one item carries an op, a target reading, a
//   brightness and a refresh flag. A sample moves the tracked value one count toward
//   the target (after the CO2 or pressure floor) and, when the value has changed or a
//   refresh is forced, yields one gauge item on the result channel
//   (out_valid/out_ready). A clear op zeroes the tracked and shown values and yields
//   nothing; so does a sample while the mode register holds an unused code.
//   Path: the accepting edge loads the input register, and the result register is loaded
//   from it once that register is free or being drained.
//   Throughput: one item per cycle, sustained while out_ready stays high; the step-and-map
//   logic between the input register and the result register is a single pass with no loop.
//   Stall: while a result waits on out_ready the input register still takes one more
//   item; that item then holds until the result register is freed.
//   Reset (rst_n low, synchronous): both registers empty, tracked and shown values
//   zero, mode CO2.
//   Register port: APB style, zero wait states; the sensor mode register sits at byte
//   address 0. Write it only while the block is idle.
`default_nettype none

module slewed_sensor_gauge_mapper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_op,
  input  wire logic [15:0] in_target_value,
  input  wire logic [7:0]  in_brightness,
  input  wire logic        in_force_refresh,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_bar_length,
  output logic [3:0]       out_front_color,
  output logic [3:0]       out_back_color,
  output logic [7:0]       out_level_brightness,
  output logic [15:0]      out_shown_value,
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ssgm_pkg::*;

  // Input register
  logic        in_valid_r;
  logic        op_r;
  logic [15:0] target_r;
  logic [7:0]  bright_r;
  logic        force_r;

  // State
  logic [15:0] tracked_r, tracked_nxt;
  logic [15:0] shown_r, shown_nxt;
  logic [2:0]  mode_r;

  // Result register
  logic        out_valid_r;
  logic [5:0]  len_r, len_nxt;
  color_t      front_r, front_nxt;
  color_t      back_r, back_nxt;
  logic [7:0]  obright_r;
  logic [15:0] oshown_r;

  logic        advance;
  logic        emit;
  logic        cfg_wr;
  logic [15:0] floored;
  logic [15:0] stepped;
  logic [15:0] d;

  // Move the held item on once the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_SENSOR_MODE) ? {29'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CO2;
    end else if (cfg_wr && cfg_paddr[2] == REG_SENSOR_MODE) begin
      mode_r <= cfg_pwdata[2:0];
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r     <= in_op;
      target_r <= in_target_value;
      bright_r <= in_brightness;
      force_r  <= in_force_refresh;
    end
  end

  // Step, decide on a result, and map the value onto the mode's bands
  always_comb begin
    floored = tracked_r;
    if (mode_r == MODE_CO2 && tracked_r < CO2_FLOOR) begin
      floored = CO2_FLOOR;
    end
    if (mode_r == MODE_PRESSURE && tracked_r < PRESSURE_FLOOR) begin
      floored = PRESSURE_FLOOR;
    end
    if (floored < target_r) begin
      stepped = floored + 16'd1;
    end else if (floored > target_r) begin
      stepped = floored - 16'd1;
    end else begin
      stepped = floored;
    end

    tracked_nxt = tracked_r;
    shown_nxt   = shown_r;
    emit        = 1'b0;
    if (op_r == OP_CLEAR) begin
      tracked_nxt = 16'd0;
      shown_nxt   = 16'd0;
    end else if (mode_r <= MODE_PRESSURE) begin
      tracked_nxt = stepped;
      if (stepped != shown_r || force_r) begin
        emit      = 1'b1;
        shown_nxt = stepped;
      end
    end

    d         = 16'd0;
    len_nxt   = BAR_HALF;
    front_nxt = COL_BLUE;
    back_nxt  = COL_BLUE;
    case (mode_r)
      MODE_CO2: begin
        if (stepped <= 16'd352) begin
          len_nxt = BAR_HALF; front_nxt = COL_BLUE; back_nxt = COL_BLUE;
        end else if (stepped <= 16'd448) begin
          d = stepped - 16'd352;
          len_nxt = {1'b0, div6(d[6:0])}; front_nxt = COL_GREEN; back_nxt = COL_BLUE;
        end else if (stepped <= 16'd544) begin
          d = stepped - 16'd448;
          len_nxt = {1'b0, div6(d[6:0])}; front_nxt = COL_YELLOW; back_nxt = COL_GREEN;
        end else if (stepped <= 16'd640) begin
          d = stepped - 16'd544;
          len_nxt = {1'b0, div6(d[6:0])}; front_nxt = COL_RED; back_nxt = COL_YELLOW;
        end else if (stepped <= 16'd736) begin
          d = stepped - 16'd640;
          len_nxt = {1'b0, div6(d[6:0])}; front_nxt = COL_MAGENTA; back_nxt = COL_RED;
        end else begin
          len_nxt = BAR_HALF; front_nxt = COL_MAGENTA; back_nxt = COL_MAGENTA;
        end
      end
      MODE_PM10: begin
        if (stepped == 16'd0) begin
          len_nxt = BAR_HALF; front_nxt = COL_BLUE; back_nxt = COL_BLUE;
        end else if (stepped <= 16'd16) begin
          len_nxt = stepped[5:0]; front_nxt = COL_GREEN; back_nxt = COL_BLUE;
        end else if (stepped <= 16'd48) begin
          d = stepped - 16'd16;
          len_nxt = {1'b0, d[5:1]}; front_nxt = COL_YELLOW; back_nxt = COL_GREEN;
        end else if (stepped <= 16'd128) begin
          d = stepped - 16'd48;
          len_nxt = {1'b0, div5(d[6:0])}; front_nxt = COL_RED; back_nxt = COL_YELLOW;
        end else if (stepped <= 16'd176) begin
          d = stepped - 16'd128;
          len_nxt = {1'b0, div3(d[5:0])}; front_nxt = COL_MAGENTA; back_nxt = COL_RED;
        end else begin
          len_nxt = BAR_HALF; front_nxt = COL_MAGENTA; back_nxt = COL_MAGENTA;
        end
      end
      MODE_PM2_5: begin
        if (stepped == 16'd0) begin
          len_nxt = BAR_HALF; front_nxt = COL_BLUE; back_nxt = COL_BLUE;
        end else if (stepped <= 16'd16) begin
          len_nxt = stepped[5:0]; front_nxt = COL_GREEN; back_nxt = COL_BLUE;
        end else if (stepped <= 16'd32) begin
          d = stepped - 16'd16;
          len_nxt = d[5:0]; front_nxt = COL_YELLOW; back_nxt = COL_GREEN;
        end else if (stepped <= 16'd80) begin
          d = stepped - 16'd32;
          len_nxt = {1'b0, div3(d[5:0])}; front_nxt = COL_RED; back_nxt = COL_YELLOW;
        end else if (stepped <= 16'd128) begin
          d = stepped - 16'd80;
          len_nxt = {1'b0, div3(d[5:0])}; front_nxt = COL_MAGENTA; back_nxt = COL_RED;
        end else begin
          len_nxt = BAR_HALF; front_nxt = COL_MAGENTA; back_nxt = COL_MAGENTA;
        end
      end
      MODE_TEMP: begin
        if (stepped <= 16'd16) begin
          len_nxt = BAR_HALF; front_nxt = COL_DARKBLUE; back_nxt = COL_DARKBLUE;
        end else if (stepped <= 16'd32) begin
          d = stepped - 16'd16;
          len_nxt = d[5:0]; front_nxt = COL_ORANGE; back_nxt = COL_DARKBLUE;
        end else begin
          len_nxt = BAR_HALF; front_nxt = COL_ORANGE; back_nxt = COL_ORANGE;
        end
      end
      MODE_HUMIDITY: begin
        if (stepped <= 16'd16) begin
          len_nxt = BAR_HALF; front_nxt = COL_DARKBLUE; back_nxt = COL_DARKBLUE;
        end else if (stepped <= 16'd80) begin
          d = stepped - 16'd16;
          len_nxt = {1'b0, d[6:2]}; front_nxt = COL_CYAN; back_nxt = COL_DARKBLUE;
        end else begin
          len_nxt = BAR_HALF; front_nxt = COL_CYAN; back_nxt = COL_CYAN;
        end
      end
      MODE_PRESSURE: begin
        // Eight counts per band, two segments per count
        if (stepped <= 16'd976) begin
          len_nxt = BAR_HALF; front_nxt = COL_DARKBLUE; back_nxt = COL_DARKBLUE;
        end else if (stepped <= 16'd984) begin
          d = stepped - 16'd976;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_BLUE; back_nxt = COL_DARKBLUE;
        end else if (stepped <= 16'd992) begin
          d = stepped - 16'd984;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_CYAN; back_nxt = COL_BLUE;
        end else if (stepped <= 16'd1000) begin
          d = stepped - 16'd992;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_GREEN; back_nxt = COL_CYAN;
        end else if (stepped <= 16'd1008) begin
          d = stepped - 16'd1000;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_GREENYELLOW; back_nxt = COL_GREEN;
        end else if (stepped <= 16'd1016) begin
          d = stepped - 16'd1008;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_YELLOW;
          back_nxt = COL_GREENYELLOW;
        end else if (stepped <= 16'd1024) begin
          d = stepped - 16'd1016;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_ORANGE; back_nxt = COL_YELLOW;
        end else if (stepped <= 16'd1032) begin
          d = stepped - 16'd1024;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_RED; back_nxt = COL_ORANGE;
        end else if (stepped <= 16'd1040) begin
          d = stepped - 16'd1032;
          len_nxt = {1'b0, d[3:0], 1'b0}; front_nxt = COL_MAGENTA; back_nxt = COL_RED;
        end else begin
          len_nxt = BAR_FULL; front_nxt = COL_MAGENTA; back_nxt = COL_MAGENTA;
        end
      end
      default: begin
        len_nxt = BAR_HALF; front_nxt = COL_BLUE; back_nxt = COL_BLUE;
      end
    endcase
  end

  // Commit the state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r <= 16'd0;
      shown_r   <= 16'd0;
    end else if (advance) begin
      tracked_r <= tracked_nxt;
      shown_r   <= shown_nxt;
    end
  end

  // Result register: drop a taken result, load a fresh one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      len_r     <= len_nxt;
      front_r   <= front_nxt;
      back_r    <= back_nxt;
      obright_r <= bright_r;
      oshown_r  <= stepped;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_bar_length       = len_r;
  assign out_front_color      = front_r;
  assign out_back_color       = back_r;
  assign out_level_brightness = obright_r;
  assign out_shown_value      = oshown_r;

endmodule

`default_nettype wire

// ----- design/ssgm_checker.sv -----
// Port-level checks for the slewed sensor gauge mapper, bound to the top level.
`default_nettype none

module ssgm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [5:0]  out_bar_length,
  input wire logic [3:0]  out_front_color,
  input wire logic [3:0]  out_back_color,
  input wire logic [7:0]  out_level_brightness,
  input wire logic [15:0] out_shown_value
);
  import ssgm_pkg::*;

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bar_length)
      && $stable(out_front_color) && $stable(out_back_color)
      && $stable(out_level_brightness) && $stable(out_shown_value))
    else $error("stalled result changed");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_bar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bar_length <= BAR_FULL)
    else $error("bar length out of range");

  // Matching colours only on the saturated ends of a band table
  a_flat_bar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_front_color == out_back_color
      |-> out_bar_length == BAR_HALF || out_bar_length == BAR_FULL)
    else $error("flat gauge with partial bar");

endmodule

bind slewed_sensor_gauge_mapper ssgm_checker u_ssgm_checker (.*);

`default_nettype wire
